@@ rtl/u8bd_pkg.sv @@
`default_nettype none
package u8bd_pkg;

	localparam int unsigned COLUMN_BITS_DEF = 16;
	localparam int unsigned CP_BITS         = 16;
	localparam int unsigned PARTIAL_BITS    = 21;

	localparam logic [CP_BITS-1:0] FALLBACK_CP = 16'h30FB;
	localparam logic [CP_BITS-1:0] ASCII_LIMIT = 16'h0080;

	// continuation and lead byte classes
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	typedef struct packed {
		logic [CP_BITS-1:0] code_point;
		logic               substituted;
		logic [15:0]        column_total;
		logic               run_end;
		logic               string_end;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage
`default_nettype wire

@@ rtl/u8bd_out_fifo.sv @@
`default_nettype none
module u8bd_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire u8bd_pkg::push_t  push,
	input  wire logic             pop,
	output logic                  room,
	output logic                  head_valid,
	output u8bd_pkg::result_t     head
);
	import u8bd_pkg::*;

	result_t    mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	// a push may carry two results, so it needs the whole buffer free after this pop
	assign room       = (count_q == 2'd0) || (count_q == 2'd1 && pop);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[~wr_ptr_q] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ push.count[0];
			rd_ptr_q <= rd_ptr_q ^ pop;
			count_q  <= count_q - {1'b0, pop} + push.count;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> count_q == 2'd0 || (count_q == 2'd1 && pop))
		else $error("push without room");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty buffer");

endmodule
`default_nettype wire

@@ rtl/utf8_bmp_decoder_columns.sv @@
`default_nettype none
// An input transfer is held in the input register, then decoded into a two-entry result
// buffer, from which its first result is presented.
// Throughput: one byte per cycle while out_stall is low; a byte giving two results stalls the
// input while both are buffered, bounded by the single result port.
// Reset (arst_n low, asynchronous): no sequence open, column count and halt flag cleared,
// input register and result buffer empty.
module utf8_bmp_decoder_columns #(
	parameter int unsigned COLUMN_BITS = u8bd_pkg::COLUMN_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_point,
	output logic             substituted,
	output logic [15:0]      column_total,
	output logic             run_end,
	output logic             string_end
);
	import u8bd_pkg::*;

	localparam int unsigned EXT_BITS = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// decoder state
	logic [1:0]              pend_q;
	logic [PARTIAL_BITS-1:0] partial_q;
	logic [COLUMN_BITS-1:0]  col_q;
	logic                    halted_q;

	logic    room, pop, advance;
	push_t   push;
	result_t head;

	assign pop      = out_valid && !out_stall;
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			fin_s1  <= final_byte;
		end
	end

	function automatic logic [COLUMN_BITS-1:0] col_add(
		input logic [COLUMN_BITS-1:0] c,
		input logic                   h,
		input logic [CP_BITS-1:0]     cp
	);
		logic [COLUMN_BITS:0] sum;
		sum = {1'b0, c} + ((cp < ASCII_LIMIT) ? (COLUMN_BITS+1)'(1) : (COLUMN_BITS+1)'(2));
		if (h || cp == '0) begin
			return c;
		end else if (sum[COLUMN_BITS]) begin
			return '1;
		end else begin
			return sum[COLUMN_BITS-1:0];
		end
	endfunction

	function automatic logic [15:0] col_low(input logic [COLUMN_BITS-1:0] c);
		logic [EXT_BITS-1:0] ext;
		ext = EXT_BITS'(c);
		return ext[15:0];
	endfunction

	// decode: up to two results; a fallback for an interrupted sequence comes first
	logic                    first_en, second_en;
	logic [CP_BITS-1:0]      first_cp, second_cp;
	logic                    second_sub;
	logic [1:0]              pend_d;
	logic [PARTIAL_BITS-1:0] partial_d, shifted;
	logic [COLUMN_BITS-1:0]  col_a, col_b;
	logic                    halt_a, halt_b, is_cont, fresh;

	always_comb begin
		first_en   = 1'b0;
		first_cp   = FALLBACK_CP;
		second_en  = 1'b0;
		second_cp  = FALLBACK_CP;
		second_sub = 1'b1;
		pend_d     = pend_q;
		partial_d  = partial_q;
		fresh      = 1'b0;
		is_cont    = (byte_s1 & CONT_MASK) == CONT_CODE;
		shifted    = {partial_q[PARTIAL_BITS-7:0], byte_s1[5:0]};

		if (pend_q != 2'd0) begin
			if (is_cont) begin
				pend_d    = pend_q - 2'd1;
				partial_d = shifted;
				if (pend_q == 2'd1) begin
					partial_d = '0;
					second_en = 1'b1;
					if (shifted[PARTIAL_BITS-1:CP_BITS] == '0) begin
						second_cp  = shifted[CP_BITS-1:0];
						second_sub = 1'b0;
					end
				end else if (fin_s1) begin
					second_en = 1'b1;
				end
			end else begin
				first_en  = 1'b1;
				pend_d    = 2'd0;
				partial_d = '0;
				fresh     = 1'b1;
			end
		end else begin
			fresh = 1'b1;
		end

		if (fresh) begin
			if (!byte_s1[7]) begin
				second_en  = 1'b1;
				second_cp  = CP_BITS'(byte_s1);
				second_sub = 1'b0;
			end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
				pend_d    = 2'd1;
				partial_d = PARTIAL_BITS'(byte_s1[4:0]);
				second_en = fin_s1;
			end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
				pend_d    = 2'd2;
				partial_d = PARTIAL_BITS'(byte_s1[3:0]);
				second_en = fin_s1;
			end else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE) begin
				pend_d    = 2'd3;
				partial_d = PARTIAL_BITS'(byte_s1[2:0]);
				second_en = fin_s1;
			end else begin
				second_en = 1'b1;
			end
		end

		col_a  = first_en ? col_add(col_q, halted_q, first_cp) : col_q;
		halt_a = halted_q || (first_en && first_cp == '0);
		col_b  = second_en ? col_add(col_a, halt_a, second_cp) : col_a;
		halt_b = halt_a || (second_en && second_cp == '0);

		// pack results into the low slots
		push.count = advance ? (2'(first_en) + 2'(second_en)) : 2'd0;
		push.r1.code_point   = second_cp;
		push.r1.substituted  = second_sub;
		push.r1.column_total = col_low(col_b);
		push.r1.run_end      = 1'b1;
		push.r1.string_end   = fin_s1;
		if (first_en) begin
			push.r0.code_point   = first_cp;
			push.r0.substituted  = 1'b1;
			push.r0.column_total = col_low(col_a);
			push.r0.run_end      = !second_en;
			push.r0.string_end   = fin_s1 && !second_en;
		end else begin
			push.r0 = push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 2'd0;
			partial_q <= '0;
			col_q     <= '0;
			halted_q  <= 1'b0;
		end else if (advance) begin
			if (fin_s1) begin
				pend_q    <= 2'd0;
				partial_q <= '0;
				col_q     <= '0;
				halted_q  <= 1'b0;
			end else begin
				pend_q    <= pend_d;
				partial_q <= partial_d;
				col_q     <= col_b;
				halted_q  <= halt_b;
			end
		end
	end

	u8bd_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room       (room),
		.head_valid (out_valid),
		.head       (head)
	);

	assign code_point   = head.code_point;
	assign substituted  = head.substituted;
	assign column_total = head.column_total;
	assign run_end      = head.run_end;
	assign string_end   = head.string_end;

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fin_s1 |=> pend_q == 2'd0 && col_q == '0 && !halted_q)
		else $error("state not cleared after end of string");
	a_halt_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && !(advance && fin_s1) |=> $stable(col_q))
		else $error("column count moved while halted");
	a_fin_emits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fin_s1 |-> push.count != 2'd0)
		else $error("final byte gave no result");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && !room)
		else $error("input stalled with free input register");

endmodule
`default_nettype wire

@@ verif/utf8_bmp_decoder_columns_tb.sv @@
`timescale 1ns / 100ps

module utf8_bmp_decoder_columns_tb;
	import u8bd_pkg::*;

	class decode_scoreboard;
		result_t     want_q[$];
		result_t     step_q[$];
		logic [1:0]  pend;
		logic [20:0] partial;
		logic [15:0] cols;
		bit          halted;
		int unsigned n_results;
		int unsigned n_subst;
		int unsigned n_pairs;
		int unsigned n_errors;

		function void clear_string();
			pend = 2'd0;
			partial = 21'd0;
			cols = 16'd0;
			halted = 1'b0;
		endfunction

		function void emit(logic [15:0] cp, bit subst);
			result_t r;
			logic [16:0] sum;
			if (!halted) begin
				if (cp == 16'd0) begin
					halted = 1'b1;
				end else begin
					sum = {1'b0, cols} + ((cp < ASCII_LIMIT) ? 17'd1 : 17'd2);
					cols = sum[16] ? 16'hFFFF : sum[15:0];
				end
			end
			r.code_point = cp;
			r.substituted = subst;
			r.column_total = cols;
			r.run_end = 1'b0;
			r.string_end = 1'b0;
			step_q = {step_q, r};
		endfunction

		// decode a byte with no sequence open
		function void open_fresh(logic [7:0] b, bit fin);
			if (b < CONT_CODE) begin
				emit({8'h00, b}, 1'b0);
				return;
			end
			if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				pend = 2'd1;
				partial = {16'd0, b[4:0]};
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				pend = 2'd2;
				partial = {17'd0, b[3:0]};
			end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
				pend = 2'd3;
				partial = {18'd0, b[2:0]};
			end else begin
				emit(FALLBACK_CP, 1'b1);
				return;
			end
			if (fin) begin
				pend = 2'd0;
				partial = 21'd0;
				emit(FALLBACK_CP, 1'b1);
			end
		endfunction

		function void note_byte(logic [7:0] b, bit fin);
			logic [20:0] cp21;
			result_t     r;
			step_q.delete();
			if (pend != 2'd0) begin
				if ((b & CONT_MASK) == CONT_CODE) begin
					partial = {partial[14:0], b[5:0]};
					pend = pend - 2'd1;
					if (pend == 2'd0) begin
						cp21 = partial;
						partial = 21'd0;
						if (cp21 > 21'h00FFFF)
							emit(FALLBACK_CP, 1'b1);
						else
							emit(cp21[15:0], 1'b0);
					end else if (fin) begin
						pend = 2'd0;
						partial = 21'd0;
						emit(FALLBACK_CP, 1'b1);
					end
				end else begin
					// sequence broken: fallback, then decode this byte anew
					pend = 2'd0;
					partial = 21'd0;
					emit(FALLBACK_CP, 1'b1);
					open_fresh(b, fin);
				end
			end else begin
				open_fresh(b, fin);
			end
			if (step_q.size() > 0) begin
				r = step_q.pop_back();
				r.run_end = 1'b1;
				r.string_end = fin;
				step_q = {step_q, r};
			end
			if (fin)
				clear_string();
			if (step_q.size() == 2)
				n_pairs++;
			foreach (step_q[i]) begin
				if (step_q[i].substituted)
					n_subst++;
				want_q = {want_q, step_q[i]};
			end
			n_results += step_q.size();
		endfunction

		function void field_check(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
				n_errors++;
			end
		endfunction

		function void check_result(logic [15:0] cp, logic subst, logic [15:0] ctot,
			logic r_end, logic s_end);
			result_t w;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected result, actual cp %h subst %b cols %h ends %b%b",
					$time, cp, subst, ctot, r_end, s_end);
				n_errors++;
				return;
			end
			w = want_q.pop_front();
			field_check("code_point", w.code_point, cp);
			field_check("substituted", w.substituted, subst);
			field_check("column_total", w.column_total, ctot);
			field_check("run_end", w.run_end, r_end);
			field_check("string_end", w.string_end, s_end);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'h00;
	logic        final_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] code_point;
	logic        substituted;
	logic [15:0] column_total;
	logic        run_end;
	logic        string_end;

	decode_scoreboard sb;
	logic [7:0]  byte_q[$];
	int unsigned send_idle = 0;
	int unsigned stall_pct = 0;
	int unsigned n_bytes = 0;
	int unsigned n_strings = 0;

	utf8_bmp_decoder_columns DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_point(code_point),
		.substituted(substituted),
		.column_total(column_total),
		.run_end(run_end),
		.string_end(string_end)
	);

	always #6 clk = ~clk;

	// result side: check accepted transfer, then pick next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(code_point, substituted, column_total, run_end, string_end);
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_byte(input logic [7:0] b, input bit fin);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b, fin);
		n_bytes++;
	endtask

	task automatic send_string();
		int unsigned i;
		for (i = 0; i < byte_q.size(); i++)
			send_byte(byte_q[i], i == byte_q.size() - 1);
		byte_q.delete();
		n_strings++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.want_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] cont_byte();
		return CONT_CODE | 8'($urandom_range(63));
	endfunction

	function automatic void push_char();
		int unsigned pick;
		int unsigned nlen;
		int unsigned k;
		pick = $urandom_range(99);
		if (pick < 38) begin
			byte_q = {byte_q, 8'($urandom_range(127, 1))};
		end else if (pick < 42) begin
			byte_q = {byte_q, 8'h00};
		end else if (pick < 58) begin
			byte_q = {byte_q, LEAD2_CODE | 8'($urandom_range(31))};
			byte_q = {byte_q, cont_byte()};
		end else if (pick < 72) begin
			byte_q = {byte_q, LEAD3_CODE | 8'($urandom_range(15))};
			byte_q = {byte_q, cont_byte()};
			byte_q = {byte_q, cont_byte()};
		end else if (pick < 80) begin
			// half of these stay within the BMP
			if ($urandom_range(1)) begin
				byte_q = {byte_q, LEAD4_CODE};
				byte_q = {byte_q, CONT_CODE | 8'($urandom_range(15))};
			end else begin
				byte_q = {byte_q, LEAD4_CODE | 8'($urandom_range(7))};
				byte_q = {byte_q, cont_byte()};
			end
			byte_q = {byte_q, cont_byte()};
			byte_q = {byte_q, cont_byte()};
		end else if (pick < 88) begin
			// sequence cut short
			nlen = $urandom_range(4, 2);
			if (nlen == 2)
				byte_q = {byte_q, LEAD2_CODE | 8'($urandom_range(31))};
			else if (nlen == 3)
				byte_q = {byte_q, LEAD3_CODE | 8'($urandom_range(15))};
			else
				byte_q = {byte_q, LEAD4_CODE | 8'($urandom_range(7))};
			for (k = $urandom_range(nlen - 2); k > 0; k--)
				byte_q = {byte_q, cont_byte()};
		end else begin
			byte_q = {byte_q, 8'($urandom_range(255))};
		end
	endfunction

	task automatic run_phase(input int unsigned idle_p, input int unsigned stall_p,
		input int unsigned target);
		int unsigned sent;
		int unsigned nchars;
		send_idle = idle_p;
		stall_pct = stall_p;
		sent = 0;
		while (sent < target) begin
			for (nchars = $urandom_range(10, 1); nchars > 0; nchars--)
				push_char();
			sent += byte_q.size();
			send_string();
			if ($urandom_range(29) == 0)
				wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		sb = new;
		sb.clear_string();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ASCII extremes, NUL freezes the count
		byte_q = '{8'h41, 8'h7F, 8'h00, 8'h41};
		send_string();
		// 2-, 3-, 4-byte forms; the 4-byte one lands above the BMP
		byte_q = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
			8'hEF, 8'hBF, 8'hBF};
		send_string();
		// stray continuation, invalid lead, broken sequence, break on final byte
		byte_q = '{8'h80, 8'hFF, 8'hE2, 8'h41, 8'hE2, 8'hC2};
		send_string();
		// overlong NUL
		byte_q = '{8'hC0, 8'h80, 8'h41};
		send_string();
		// truncated at end of text
		byte_q = '{8'hE2, 8'h82};
		send_string();
		byte_q = '{8'hF4};
		send_string();
		wait_drain();

		run_phase(0, 0, 325);
		run_phase(86, 0, 325);
		run_phase(0, 86, 325);
		run_phase(12, 12, 325);

		wait_drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes in %0d strings; %0d results, %0d substituted, %0d bytes with two.",
			n_bytes, n_strings, sb.n_results, sb.n_subst, sb.n_pairs);
		$display("Covered valid, overlong, truncated and broken sequences under varied idle/stall.");
		if (sb.n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/u8bd_pkg.sv
rtl/u8bd_out_fifo.sv
rtl/utf8_bmp_decoder_columns.sv
verif/utf8_bmp_decoder_columns_tb.sv
